@@ src/fnfba_pkg.sv @@
// ----------------------------------------------------------------------------
// fnfba_pkg
// Shared types, codes and default sizes for the first/next-fit block
// allocator: transaction payloads, controller states and command/status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package fnfba_pkg;

    // Default sizing
    localparam int DEF_MAX_BLOCKS   = 64;
    localparam int DEF_HEAP_BYTES   = 65536;
    localparam int DEF_WORD_BYTES   = 8;
    localparam int DEF_HEADER_BYTES = 24;

    // Request actions
    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_RESET = 2'd2;
    localparam logic [1:0] ACT_NOP   = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OOM     = 2'd1;
    localparam logic [1:0] ST_NOMATCH = 2'd2;

    // Search modes
    localparam logic FIRST_FIT = 1'b0;
    localparam logic NEXT_FIT  = 1'b1;

    // Input transaction
    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] request_bytes;
        logic [15:0] free_address;
    } req_t;

    // Result transaction
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] data_address;
        logic [15:0] granted_bytes;
    } rsp_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ROUND,
        S_CHECK,
        S_SCAN,
        S_HIT,
        S_APPEND
    } ctl_state_t;

    // How a request finishes
    typedef enum logic [2:0] {
        FIN_NONE,
        FIN_ZERO,
        FIN_RESET,
        FIN_OOM,
        FIN_NOMATCH,
        FIN_HIT,
        FIN_APPEND
    } fin_t;

    // Controller -> datapath
    typedef struct packed {
        logic load_req;
        logic scan_load;
        logic scan_en;
        fin_t fin;
    } ctl_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic [1:0] action;
        logic       need_oom;
        logic       hit;
        logic       miss;
    } dp_stat_t;

endpackage

@@ src/fnfba_ctrl.sv @@
// ----------------------------------------------------------------------------
// fnfba_ctrl
// Sequencer for the allocator: decodes a request, steps the datapath through
// size rounding, table scan and the final update, one request at a time.
// ----------------------------------------------------------------------------
module fnfba_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  fnfba_pkg::dp_stat_t stat,
    output fnfba_pkg::ctl_cmd_t cmd
);

    fnfba_pkg::ctl_state_t state_reg;
    fnfba_pkg::ctl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fnfba_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fnfba_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = fnfba_pkg::S_DECODE;
                end
            end
            fnfba_pkg::S_DECODE:
            begin
                case (stat.action)
                    fnfba_pkg::ACT_ALLOC: state_next = fnfba_pkg::S_ROUND;
                    fnfba_pkg::ACT_FREE:  state_next = fnfba_pkg::S_SCAN;
                    default:              state_next = fnfba_pkg::S_IDLE;
                endcase
            end
            fnfba_pkg::S_ROUND:
            begin
                state_next = fnfba_pkg::S_CHECK;
            end
            fnfba_pkg::S_CHECK:
            begin
                state_next = stat.need_oom ? fnfba_pkg::S_IDLE : fnfba_pkg::S_SCAN;
            end
            fnfba_pkg::S_SCAN:
            begin
                if (stat.hit)
                begin
                    state_next = fnfba_pkg::S_HIT;
                end
                else if (stat.miss)
                begin
                    state_next = (stat.action == fnfba_pkg::ACT_ALLOC) ?
                                 fnfba_pkg::S_APPEND : fnfba_pkg::S_IDLE;
                end
            end
            fnfba_pkg::S_HIT:    state_next = fnfba_pkg::S_IDLE;
            fnfba_pkg::S_APPEND: state_next = fnfba_pkg::S_IDLE;
            default:             state_next = fnfba_pkg::S_IDLE;
        endcase
    end

    // Command outputs
    always_comb
    begin
        cmd           = '0;
        cmd.fin       = fnfba_pkg::FIN_NONE;
        case (state_reg)
            fnfba_pkg::S_IDLE:
            begin
                cmd.load_req = start;
            end
            fnfba_pkg::S_DECODE:
            begin
                case (stat.action)
                    fnfba_pkg::ACT_ALLOC: cmd.fin = fnfba_pkg::FIN_NONE;
                    fnfba_pkg::ACT_FREE:  cmd.scan_load = 1'b1;
                    fnfba_pkg::ACT_RESET: cmd.fin = fnfba_pkg::FIN_RESET;
                    default:              cmd.fin = fnfba_pkg::FIN_ZERO;
                endcase
            end
            fnfba_pkg::S_CHECK:
            begin
                if (stat.need_oom)
                begin
                    cmd.fin = fnfba_pkg::FIN_OOM;
                end
                else
                begin
                    cmd.scan_load = 1'b1;
                end
            end
            fnfba_pkg::S_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (!stat.hit && stat.miss && stat.action != fnfba_pkg::ACT_ALLOC)
                begin
                    cmd.fin = fnfba_pkg::FIN_NOMATCH;
                end
            end
            fnfba_pkg::S_HIT:    cmd.fin = fnfba_pkg::FIN_HIT;
            fnfba_pkg::S_APPEND: cmd.fin = fnfba_pkg::FIN_APPEND;
            default:             cmd.fin = fnfba_pkg::FIN_NONE;
        endcase
    end

    assign busy = (state_reg != fnfba_pkg::S_IDLE);

endmodule

@@ src/fnfba_dp.sv @@
// ----------------------------------------------------------------------------
// fnfba_dp
// Allocator datapath: block table memory, heap top, block count, next-fit
// cursor, size rounding, pipelined table scan and result register.
// ----------------------------------------------------------------------------
module fnfba_dp #(
    parameter int MAX_BLOCKS   = fnfba_pkg::DEF_MAX_BLOCKS,
    parameter int HEAP_BYTES   = fnfba_pkg::DEF_HEAP_BYTES,
    parameter int WORD_BYTES   = fnfba_pkg::DEF_WORD_BYTES,
    parameter int HEADER_BYTES = fnfba_pkg::DEF_HEADER_BYTES
) (
    input  logic                clk,
    input  logic                rst_n,
    input  fnfba_pkg::req_t     request,
    input  logic                cfg_we,
    input  logic                cfg_data,
    input  fnfba_pkg::ctl_cmd_t cmd,
    output fnfba_pkg::dp_stat_t stat,
    output logic                done,
    output fnfba_pkg::rsp_t     result
);

    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int TW = $clog2(HEAP_BYTES + 1);
    localparam int SUM_W = ((TW > 17) ? TW : 17) + 2;
    // Round-up reciprocal, exact for 17-bit dividends and word sizes to 16
    localparam int RECIP_SHIFT = 22;
    localparam int PROD_W = RECIP_SHIFT + 18;
    localparam logic [RECIP_SHIFT:0] RECIP_MULT =
        (RECIP_SHIFT + 1)'((1 << RECIP_SHIFT) / WORD_BYTES + 1);

    typedef struct packed {
        logic        used;
        logic [15:0] size;
        logic [15:0] start;
    } blk_entry_t;

    // Block table
    blk_entry_t mem [MAX_BLOCKS];

    fnfba_pkg::req_t req_reg;
    logic            mode_reg;
    logic [CW-1:0]   count_reg;
    logic [TW-1:0]   top_reg;
    logic [IW-1:0]   cursor_reg;
    logic [16:0]     q_reg;
    logic [16:0]     need_reg;
    logic [IW-1:0]   idx_reg;
    logic [CW-1:0]   k_reg;
    logic            rd_valid_reg;
    logic [IW-1:0]   rd_idx_reg;
    blk_entry_t      rdata_reg;
    logic [IW-1:0]   hit_idx_reg;
    blk_entry_t      hit_reg;
    logic            done_reg;
    fnfba_pkg::rsp_t result_reg;

    logic [16:0]       round_in;
    logic [PROD_W-1:0] round_prod;
    logic              is_alloc;
    logic [IW-1:0]     start_idx;
    logic              issue;
    logic [CW-1:0]     idx_inc;
    logic              entry_match;
    logic              hit;
    logic              miss;
    logic [SUM_W-1:0]  data_sum;
    logic [SUM_W-1:0]  new_top;
    logic              append_ok;
    logic [CW-1:0]     cursor_inc;
    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    blk_entry_t        mem_wdata;

    // Request latch and size rounding pipeline
    assign round_in   = {1'b0, req_reg.request_bytes} + 17'(WORD_BYTES - 1);
    assign round_prod = PROD_W'(round_in) * PROD_W'(RECIP_MULT);

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= request;
        end
        q_reg    <= round_prod[RECIP_SHIFT+16:RECIP_SHIFT];
        need_reg <= 17'(22'(q_reg) * 22'(WORD_BYTES));
    end

    assign is_alloc = (req_reg.action == fnfba_pkg::ACT_ALLOC);

    // Scan start: next-fit allocations resume at the cursor
    assign start_idx = (is_alloc && mode_reg == fnfba_pkg::NEXT_FIT &&
                        CW'(cursor_reg) < count_reg) ? cursor_reg : '0;

    assign issue   = cmd.scan_en && (k_reg < count_reg);
    assign idx_inc = CW'(idx_reg) + 1'b1;

    // Entry compare on registered read data
    assign entry_match = is_alloc ?
                         (!rdata_reg.used && {1'b0, rdata_reg.size} >= need_reg) :
                         (rdata_reg.start == req_reg.free_address);
    assign hit  = cmd.scan_en && rd_valid_reg && entry_match;
    assign miss = cmd.scan_en && !rd_valid_reg && (k_reg == count_reg);

    // Scan counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg        <= '0;
            idx_reg      <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= issue;
            if (cmd.scan_load)
            begin
                k_reg   <= '0;
                idx_reg <= start_idx;
            end
            else if (issue)
            begin
                k_reg   <= k_reg + 1'b1;
                idx_reg <= (idx_inc == count_reg) ? '0 : idx_inc[IW-1:0];
            end
        end
    end

    // Table read port and hit capture
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rdata_reg  <= mem[idx_reg];
            rd_idx_reg <= idx_reg;
        end
        if (hit)
        begin
            hit_reg     <= rdata_reg;
            hit_idx_reg <= rd_idx_reg;
        end
    end

    // Heap growth check
    assign data_sum  = SUM_W'(top_reg) + SUM_W'(HEADER_BYTES);
    assign new_top   = data_sum + SUM_W'(need_reg);
    assign append_ok = (count_reg < CW'(MAX_BLOCKS)) &&
                       (new_top <= SUM_W'(HEAP_BYTES)) &&
                       (data_sum <= SUM_W'(16'hFFFF));

    // Table write port
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = hit_idx_reg;
        mem_wdata = hit_reg;
        if (cmd.fin == fnfba_pkg::FIN_HIT)
        begin
            mem_we         = 1'b1;
            mem_wdata.used = is_alloc;
        end
        else if (cmd.fin == fnfba_pkg::FIN_APPEND && append_ok)
        begin
            mem_we          = 1'b1;
            mem_waddr       = count_reg[IW-1:0];
            mem_wdata.used  = 1'b1;
            mem_wdata.size  = need_reg[15:0];
            mem_wdata.start = data_sum[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    assign cursor_inc = CW'(hit_idx_reg) + 1'b1;

    // Heap state and search mode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= fnfba_pkg::FIRST_FIT;
            count_reg  <= '0;
            top_reg    <= '0;
            cursor_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_data;
            end
            case (cmd.fin)
                fnfba_pkg::FIN_RESET:
                begin
                    count_reg  <= '0;
                    top_reg    <= '0;
                    cursor_reg <= '0;
                end
                fnfba_pkg::FIN_HIT:
                begin
                    if (is_alloc && mode_reg == fnfba_pkg::NEXT_FIT)
                    begin
                        cursor_reg <= (cursor_inc >= count_reg) ? '0 :
                                      cursor_inc[IW-1:0];
                    end
                end
                fnfba_pkg::FIN_APPEND:
                begin
                    if (append_ok)
                    begin
                        count_reg <= count_reg + 1'b1;
                        top_reg   <= TW'(new_top);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result register and strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cmd.fin != fnfba_pkg::FIN_NONE);
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.fin)
            fnfba_pkg::FIN_OOM:
            begin
                result_reg <= '{fnfba_pkg::ST_OOM, 16'd0, 16'd0};
            end
            fnfba_pkg::FIN_NOMATCH:
            begin
                result_reg <= '{fnfba_pkg::ST_NOMATCH, 16'd0, 16'd0};
            end
            fnfba_pkg::FIN_HIT:
            begin
                result_reg <= '{fnfba_pkg::ST_OK, hit_reg.start, hit_reg.size};
            end
            fnfba_pkg::FIN_APPEND:
            begin
                if (append_ok)
                begin
                    result_reg <= '{fnfba_pkg::ST_OK, data_sum[15:0], need_reg[15:0]};
                end
                else
                begin
                    result_reg <= '{fnfba_pkg::ST_OOM, 16'd0, 16'd0};
                end
            end
            fnfba_pkg::FIN_ZERO, fnfba_pkg::FIN_RESET:
            begin
                result_reg <= '{fnfba_pkg::ST_OK, 16'd0, 16'd0};
            end
            default:
            begin
            end
        endcase
    end

    assign stat.action   = req_reg.action;
    assign stat.need_oom = need_reg[16];
    assign stat.hit      = hit;
    assign stat.miss     = miss;
    assign done          = done_reg;
    assign result        = result_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_BLOCKS))
        else $error("block count beyond table depth");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cursor_reg == '0) || (CW'(cursor_reg) < count_reg))
        else $error("next-fit cursor outside the table");

    a_hit_miss: assert property (@(posedge clk) disable iff (!rst_n)
        !(hit && miss))
        else $error("scan reported hit and miss together");

    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(cmd.fin != fnfba_pkg::FIN_NONE))
        else $error("result strobe without a finishing command");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (result_reg.status == fnfba_pkg::ST_OK ||
                      result_reg.status == fnfba_pkg::ST_OOM ||
                      result_reg.status == fnfba_pkg::ST_NOMATCH))
        else $error("undefined status code");

endmodule

@@ src/first_next_fit_block_allocator.sv @@
// ----------------------------------------------------------------------------
// first_next_fit_block_allocator
// Heap block allocator with first-fit or next-fit search over a block table.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive request and raise start; the transaction is taken
//   on a clock edge with start high and busy low. One request at a time.
//   Result channel: done pulses for one cycle with result valid; the
//   receiver cannot stall it and must take it in that cycle.
//   Config channel: cfg_data bit selects first-fit (0) or next-fit (1); it is written
//   on cfg_valid and cfg_ready high; write it only while no request is pending, which the block does not enforce.
// Sequence, from the accepting edge to the done cycle:
//   allocate: decode, size rounding and heap check, a scan of one table
//   entry per cycle through the single registered read port, then the
//   update; free: decode, then the scan and the update; heap reset and
//   no-op: decode only. busy drops in the done cycle, so the next request
//   can be taken then; no new request is taken while one is in flight.
// Reset: rst_n clears the heap (no blocks, top at 0, cursor at 0) and
//   selects first-fit. The table memory needs no clearing since only
//   entries below the block count are read.
// ----------------------------------------------------------------------------
module first_next_fit_block_allocator #(
    parameter int MAX_BLOCKS   = fnfba_pkg::DEF_MAX_BLOCKS,
    parameter int HEAP_BYTES   = fnfba_pkg::DEF_HEAP_BYTES,
    parameter int WORD_BYTES   = fnfba_pkg::DEF_WORD_BYTES,
    parameter int HEADER_BYTES = fnfba_pkg::DEF_HEADER_BYTES
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  fnfba_pkg::req_t request,
    output logic            done,
    output fnfba_pkg::rsp_t result,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic            cfg_data
);

    fnfba_pkg::ctl_cmd_t cmd;
    fnfba_pkg::dp_stat_t stat;

    // Mode register is always writable
    assign cfg_ready = 1'b1;

    fnfba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    fnfba_dp #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEAP_BYTES   (HEAP_BYTES),
        .WORD_BYTES   (WORD_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .cfg_we   (cfg_valid & cfg_ready),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .stat     (stat),
        .done     (done),
        .result   (result)
    );

endmodule
